FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk with reset rst_n.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define AST_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define AST_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: rtl/hofmt_pkg.sv
// ----------------------------------------------------------------------------
// Hex/octal field formatter package
// Request and result types, character codes and pad mode codes.
// ----------------------------------------------------------------------------
package hofmt_pkg;

  localparam int CNT_W = 7;

  localparam logic [6:0] CH_ZERO    = 7'd48;
  localparam logic [6:0] CH_NINE    = 7'd57;
  localparam logic [6:0] CH_SPACE   = 7'd32;
  localparam logic [6:0] LOWER_GAP  = 7'd39;
  localparam logic [6:0] CASE_GAP   = 7'd32;
  localparam logic [6:0] CH_LOWER_X = 7'd120;

  localparam logic [1:0] PAD_PLAIN = 2'd0;
  localparam logic [1:0] PAD_LEFT  = 2'd1;
  localparam logic [1:0] PAD_ALT   = 2'd2;
  localparam logic [1:0] PAD_ZERO  = 2'd3;

  typedef struct packed {
    logic [63:0] value;
    logic        radix_octal;
    logic        upper_case;
    logic [1:0]  pad_mode;
    logic [5:0]  field_width;
    logic [5:0]  min_digits;
  } hofmt_in_t;

  typedef struct packed {
    logic [6:0] out_char;
    logic       last_char;
  } hofmt_out_t;

  typedef struct packed {
    logic load;
    logic shift;
    logic octal;
    logic upper;
  } hofmt_dig_ctl_t;

endpackage

FILE: rtl/hofmt_digit_unit.sv
// ----------------------------------------------------------------------------
// Digit shift unit
// Holds the value left-aligned on digit boundaries and presents its top digit
// as an ASCII character; one shifter serves both leading-zero skip and output.
// ----------------------------------------------------------------------------
module hofmt_digit_unit #(
  parameter int VALUE_BITS = 64
) (
  input  logic                    clk,
  input  hofmt_pkg::hofmt_dig_ctl_t ctl,
  input  logic [63:0]             value,
  output logic                    top_zero,
  output logic [6:0]              top_char
);
  import hofmt_pkg::*;

  localparam int HEX_DIGITS = (VALUE_BITS + 3) / 4;
  localparam int OCT_DIGITS = (VALUE_BITS + 2) / 3;
  localparam int HEX_W      = 4 * HEX_DIGITS;
  localparam int OCT_W      = 3 * OCT_DIGITS;
  localparam int SR_W       = (HEX_W > OCT_W) ? HEX_W : OCT_W;
  localparam int HEX_SH     = SR_W - HEX_W;
  localparam int OCT_SH     = SR_W - OCT_W;

  logic [SR_W-1:0] sr_r;
  logic [SR_W-1:0] sr_nxt;
  logic [SR_W-1:0] val_ext;
  logic [3:0]      digit;
  logic [6:0]      base_char;

  assign val_ext = SR_W'(value[VALUE_BITS-1:0]);

  always_comb begin
    sr_nxt = sr_r;
    if (ctl.load) begin
      sr_nxt = ctl.octal ? (val_ext << OCT_SH) : (val_ext << HEX_SH);
    end else if (ctl.shift) begin
      sr_nxt = ctl.octal ? (sr_r << 3) : (sr_r << 4);
    end
  end

  always_ff @(posedge clk) begin
    sr_r <= sr_nxt;
  end

  assign digit     = ctl.octal ? {1'b0, sr_r[SR_W-1 -: 3]} : sr_r[SR_W-1 -: 4];
  assign top_zero  = (digit == 4'd0);
  assign base_char = CH_ZERO + {3'b000, digit};

  always_comb begin
    top_char = base_char;
    if (base_char > CH_NINE) begin
      top_char = ctl.upper ? (base_char + LOWER_GAP - CASE_GAP)
                           : (base_char + LOWER_GAP);
    end
  end

endmodule

FILE: rtl/hex_octal_field_formatter_unit.sv
// ----------------------------------------------------------------------------
// Hex/octal field formatter
// Formats an unsigned value as padded hexadecimal or octal ASCII text.
// ----------------------------------------------------------------------------
// A request is taken at a rising edge where start is high and busy is low.
// busy then stays high until the final character has been issued, and no
// further request is taken meanwhile.
// Each character appears on out_data for exactly one cycle with out_valid
// high; out_data.last_char marks the final character of the field. The
// receiver cannot hold results off, so it must take every character.
// Sequence: after the request edge the digit shifter, in ST_SKIP, skips
// z leading zero digits (at most 21 for 64-bit octal), ST_SETUP then
// works out the field layout, and then one character leaves per cycle for
// the n characters of the field (1 to MAX_FIELD), each registered out of
// ST_EMIT. The shared digit shifter sets both the skip time and the
// one-digit-per-cycle output rate.
// A synchronous reset returns the sequencer to idle and drops out_valid;
// the digit register needs no reset.
// ----------------------------------------------------------------------------
module hex_octal_field_formatter_unit #(
  parameter int MAX_FIELD  = 62,
  parameter int VALUE_BITS = 64
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  hofmt_pkg::hofmt_in_t  in_req,
  output logic                  out_valid,
  output hofmt_pkg::hofmt_out_t out_data
);
  import hofmt_pkg::*;

  localparam int HEX_DIGITS = (VALUE_BITS + 3) / 4;
  localparam int OCT_DIGITS = (VALUE_BITS + 2) / 3;
  localparam int ND_W       = $clog2(OCT_DIGITS + 1);
  localparam logic [CNT_W-1:0] MAXF = CNT_W'(MAX_FIELD);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SKIP,
    ST_SETUP,
    ST_EMIT
  } state_t;

  state_t         state_r, state_nxt;
  logic           octal_r, upper_r;
  logic [1:0]     mode_r;
  logic [5:0]     width_r, prec_r;
  logic [ND_W-1:0] nd_r, nd_nxt;
  logic [ND_W-1:0] dig_r, dig_nxt;
  logic [CNT_W-1:0] lead_r, lead_nxt;
  logic [1:0]     pref_r, pref_nxt;
  logic [CNT_W-1:0] zeros_r, zeros_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W-1:0] total_r, total_nxt;
  logic           out_valid_r, out_valid_nxt;
  hofmt_out_t     out_r, out_nxt;

  hofmt_dig_ctl_t dig_ctl;
  logic           top_zero;
  logic [6:0]     top_char;

  logic [CNT_W-1:0] plen, width_c, prec_lim, prec_c, nd_w, eff, body, span;

  hofmt_digit_unit #(
    .VALUE_BITS(VALUE_BITS)
  ) u_digit (
    .clk     (clk),
    .ctl     (dig_ctl),
    .value   (in_req.value),
    .top_zero(top_zero),
    .top_char(top_char)
  );

  always_comb begin
    plen     = (mode_r == PAD_ALT) ? (octal_r ? CNT_W'(1) : CNT_W'(2)) : '0;
    width_c  = (CNT_W'(width_r) > MAXF) ? MAXF : CNT_W'(width_r);
    prec_lim = MAXF - plen;
    prec_c   = (CNT_W'(prec_r) > prec_lim) ? prec_lim : CNT_W'(prec_r);
    nd_w     = CNT_W'(nd_r);
    eff      = (prec_c > nd_w) ? prec_c : nd_w;
    body     = plen + eff;
    if (mode_r == PAD_ZERO) begin
      span = (width_c > nd_w) ? width_c : nd_w;
    end else begin
      span = (width_c > body) ? width_c : body;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    nd_nxt        = nd_r;
    dig_nxt       = dig_r;
    lead_nxt      = lead_r;
    pref_nxt      = pref_r;
    zeros_nxt     = zeros_r;
    cnt_nxt       = cnt_r;
    total_nxt     = total_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    dig_ctl.load  = 1'b0;
    dig_ctl.shift = 1'b0;
    dig_ctl.octal = octal_r;
    dig_ctl.upper = upper_r;
    case (state_r)
      ST_IDLE: begin
        dig_ctl.octal = in_req.radix_octal;
        dig_ctl.upper = in_req.upper_case;
        if (start) begin
          dig_ctl.load = 1'b1;
          nd_nxt       = in_req.radix_octal ? ND_W'(OCT_DIGITS) : ND_W'(HEX_DIGITS);
          state_nxt    = ST_SKIP;
        end
      end
      ST_SKIP: begin
        if (top_zero && (nd_r > ND_W'(1))) begin
          dig_ctl.shift = 1'b1;
          nd_nxt        = nd_r - ND_W'(1);
        end else begin
          state_nxt = ST_SETUP;
        end
      end
      ST_SETUP: begin
        dig_nxt   = nd_r;
        cnt_nxt   = '0;
        total_nxt = (span > MAXF) ? MAXF : span;
        pref_nxt  = plen[1:0];
        if (mode_r == PAD_ZERO) begin
          zeros_nxt = (width_c > nd_w) ? (width_c - nd_w) : '0;
          lead_nxt  = '0;
        end else begin
          zeros_nxt = eff - nd_w;
          lead_nxt  = ((mode_r != PAD_LEFT) && (width_c > body)) ? (width_c - body) : '0;
        end
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        out_valid_nxt = 1'b1;
        if (lead_r != '0) begin
          out_nxt.out_char = CH_SPACE;
          lead_nxt         = lead_r - CNT_W'(1);
        end else if (pref_r != 2'd0) begin
          if ((pref_r == 2'd1) && !octal_r) begin
            out_nxt.out_char = upper_r ? (CH_LOWER_X - CASE_GAP) : CH_LOWER_X;
          end else begin
            out_nxt.out_char = CH_ZERO;
          end
          pref_nxt = pref_r - 2'd1;
        end else if (zeros_r != '0) begin
          out_nxt.out_char = CH_ZERO;
          zeros_nxt        = zeros_r - CNT_W'(1);
        end else if (dig_r != '0) begin
          out_nxt.out_char = top_char;
          dig_ctl.shift    = 1'b1;
          dig_nxt          = dig_r - ND_W'(1);
        end else begin
          out_nxt.out_char = CH_SPACE;
        end
        out_nxt.last_char = (cnt_r == total_r - CNT_W'(1));
        cnt_nxt           = cnt_r + CNT_W'(1);
        if (out_nxt.last_char) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_r   <= out_nxt;
    nd_r    <= nd_nxt;
    dig_r   <= dig_nxt;
    lead_r  <= lead_nxt;
    pref_r  <= pref_nxt;
    zeros_r <= zeros_nxt;
    cnt_r   <= cnt_nxt;
    total_r <= total_nxt;
    if ((state_r == ST_IDLE) && start) begin
      octal_r <= in_req.radix_octal;
      upper_r <= in_req.upper_case;
      mode_r  <= in_req.pad_mode;
      width_r <= in_req.field_width;
      prec_r  <= in_req.min_digits;
    end
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

FILE: rtl/hofmt_checker.sv
// ----------------------------------------------------------------------------
// Hex/octal field formatter checker
// Port-level timing checks on the request and character channels.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hofmt_checker (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  start,
  input logic                  busy,
  input logic                  out_valid,
  input hofmt_pkg::hofmt_out_t out_data
);

  `AST_NEXT(a_take_sets_busy, start && !busy, busy)
  `AST_SAME(a_mid_char_busy, out_valid && !out_data.last_char, busy)
  `AST_NEXT(a_last_ends_field, out_valid && out_data.last_char, !out_valid)
  `AST_NEXT(a_no_char_after_take, $rose(busy), !out_valid)

endmodule

bind hex_octal_field_formatter_unit hofmt_checker u_hofmt_checker (.*);
